FILE: design/vpfa_pkg.sv
// vpfa_pkg: types, codes and sizing constants of the video payload frame assembler
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps

package vpfa_pkg;

    localparam int MAX_PACKET_BYTES = 3072;
    localparam int FRAME_LEN_BITS = 24;

    localparam int COUNT_W = 12;
    localparam int HLEN_W = 8;
    localparam int OUT_LEN_W = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W = ((FRAME_LEN_BITS > OUT_LEN_W) ? FRAME_LEN_BITS : OUT_LEN_W) + 1;

    localparam logic [COUNT_W-1:0] MAX_PKT = COUNT_W'(MAX_PACKET_BYTES);
    localparam logic [SUM_W-1:0] LEN_MASK = SUM_W'((SUM_W'(1) << FRAME_LEN_BITS) - SUM_W'(1));

    localparam logic [CFG_IDX_W-1:0] REG_STREAM_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_BYTES = 1'd1;

    localparam logic [2:0] ST_COMPLETED = 3'd0;
    localparam logic [2:0] ST_NO_DEVICE = 3'd1;
    localparam logic [2:0] ST_CANCELED = 3'd2;
    localparam logic [2:0] ST_ERROR = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_STALL = 3'd5;

    localparam logic [3:0] ACT_IGNORED = 4'd0;
    localparam logic [3:0] ACT_ABANDON = 4'd1;
    localparam logic [3:0] ACT_USB_ERR = 4'd2;
    localparam logic [3:0] ACT_NOTHING = 4'd3;
    localparam logic [3:0] ACT_SKIPPED = 4'd4;
    localparam logic [3:0] ACT_NO_BUF = 4'd5;
    localparam logic [3:0] ACT_HDR_ERR = 4'd6;
    localparam logic [3:0] ACT_OVERFLOW = 4'd7;
    localparam logic [3:0] ACT_APPENDED = 4'd8;
    localparam logic [3:0] ACT_DONE = 4'd9;

    typedef struct packed {
        logic [2:0]         xfer_status;
        logic [COUNT_W-1:0] byte_count;
        logic [HLEN_W-1:0]  header_length;
        logic               frame_id_bit;
        logic               header_error_bit;
        logic               end_frame_bit;
        logic               buffer_free;
    } item_t;

    typedef struct packed {
        logic [3:0]           action;
        logic [HLEN_W-1:0]    data_offset;
        logic [COUNT_W-1:0]   data_length;
        logic                 frame_restart;
        logic [OUT_LEN_W-1:0] frame_length;
    } result_t;

    typedef struct packed {
        logic                      cur_fid;
        logic                      skip;
        logic                      open;
        logic [FRAME_LEN_BITS-1:0] bytes;
    } state_t;

    typedef struct packed {
        logic                  stream_enable;
        logic [OUT_LEN_W-1:0]  max_frame_bytes;
    } cfg_t;

endpackage

FILE: design/vpfa_in_reg.sv
// vpfa_in_reg: input register of the packet descriptor channel
// depends on vpfa_pkg
`timescale 1ns / 1ps

module vpfa_in_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  vpfa_pkg::item_t in_item,
    output logic           in_stall,
    input  logic           advance,
    output logic           item_valid,
    output vpfa_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    logic            load;
    vpfa_pkg::item_t item_reg;

    assign load = !valid_reg || advance;
    assign valid_next = load ? in_valid : valid_reg;
    assign in_stall = !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

FILE: design/vpfa_decide.sv
// vpfa_decide: per-packet decision logic, result and next frame state
// depends on vpfa_pkg
`timescale 1ns / 1ps

module vpfa_decide (
    input  vpfa_pkg::item_t   item,
    input  vpfa_pkg::state_t  state,
    input  vpfa_pkg::cfg_t    cfg,
    output vpfa_pkg::result_t result,
    output vpfa_pkg::state_t  state_next
);

    logic [vpfa_pkg::COUNT_W-1:0]        count_sat;
    logic [vpfa_pkg::COUNT_W-1:0]        hlen_ext;
    logic [vpfa_pkg::COUNT_W-1:0]        data_len;
    logic                                fid_change;
    logic                                open_v;
    logic                                restart_v;
    logic [vpfa_pkg::FRAME_LEN_BITS-1:0] bytes_v;
    logic [vpfa_pkg::SUM_W-1:0]          cap_full;
    logic [vpfa_pkg::SUM_W-1:0]          cap;
    logic [vpfa_pkg::SUM_W-1:0]          sum;
    logic [vpfa_pkg::SUM_W-1:0]          held_ext;
    logic [vpfa_pkg::SUM_W-1:0]          start_ext;
    logic                                too_big;
    logic                                usb_err;

    assign count_sat = (item.byte_count > vpfa_pkg::MAX_PKT) ? vpfa_pkg::MAX_PKT
                                                             : item.byte_count;
    assign hlen_ext = vpfa_pkg::COUNT_W'(item.header_length);
    assign data_len = count_sat - hlen_ext;

    // frame-id toggle opens or restarts the frame
    assign fid_change = item.frame_id_bit != state.cur_fid;
    assign open_v = fid_change ? 1'b1 : state.open;
    assign restart_v = fid_change && state.open;
    assign bytes_v = fid_change ? '0 : state.bytes;

    assign cap_full = vpfa_pkg::SUM_W'(cfg.max_frame_bytes);
    assign cap = (cap_full > vpfa_pkg::LEN_MASK) ? vpfa_pkg::LEN_MASK : cap_full;
    assign sum = vpfa_pkg::SUM_W'(bytes_v) + vpfa_pkg::SUM_W'(data_len);
    assign too_big = sum > cap;
    assign held_ext = vpfa_pkg::SUM_W'(state.bytes);
    assign start_ext = vpfa_pkg::SUM_W'(bytes_v);

    assign usb_err = (item.xfer_status == vpfa_pkg::ST_ERROR)
                  || (item.xfer_status == vpfa_pkg::ST_OVERFLOW)
                  || (item.xfer_status == vpfa_pkg::ST_STALL);

    always_comb
    begin
        result.action = vpfa_pkg::ACT_IGNORED;
        result.data_offset = '0;
        result.data_length = '0;
        result.frame_restart = 1'b0;
        result.frame_length = held_ext[vpfa_pkg::OUT_LEN_W-1:0];
        state_next = state;
        priority if (!cfg.stream_enable)
        begin
            result.action = vpfa_pkg::ACT_IGNORED;
        end
        else if (item.xfer_status == vpfa_pkg::ST_NO_DEVICE
                 || item.xfer_status == vpfa_pkg::ST_CANCELED)
        begin
            result.action = vpfa_pkg::ACT_ABANDON;
        end
        else if (usb_err)
        begin
            state_next.skip = 1'b1;
            result.action = vpfa_pkg::ACT_USB_ERR;
        end
        else if (item.xfer_status != vpfa_pkg::ST_COMPLETED || item.byte_count == '0)
        begin
            result.action = vpfa_pkg::ACT_NOTHING;
        end
        else if (fid_change && !state.open && !item.buffer_free)
        begin
            state_next.cur_fid = item.frame_id_bit;
            state_next.skip = 1'b1;
            result.action = vpfa_pkg::ACT_NO_BUF;
            result.frame_length = '0;
        end
        else if (!fid_change && state.skip)
        begin
            result.action = vpfa_pkg::ACT_SKIPPED;
        end
        else
        begin
            state_next.cur_fid = item.frame_id_bit;
            state_next.skip = 1'b0;
            state_next.open = open_v;
            state_next.bytes = bytes_v;
            result.frame_restart = restart_v;
            result.frame_length = start_ext[vpfa_pkg::OUT_LEN_W-1:0];
            priority if (count_sat <= hlen_ext)
            begin
                result.action = vpfa_pkg::ACT_NOTHING;
            end
            else if (item.header_error_bit)
            begin
                state_next.skip = 1'b1;
                result.action = vpfa_pkg::ACT_HDR_ERR;
            end
            else if (!open_v || too_big)
            begin
                state_next.skip = 1'b1;
                result.action = vpfa_pkg::ACT_OVERFLOW;
            end
            else if (item.end_frame_bit)
            begin
                state_next.open = 1'b0;
                state_next.bytes = '0;
                result.action = vpfa_pkg::ACT_DONE;
                result.data_offset = item.header_length;
                result.data_length = data_len;
                result.frame_length = sum[vpfa_pkg::OUT_LEN_W-1:0];
            end
            else
            begin
                state_next.bytes = sum[vpfa_pkg::FRAME_LEN_BITS-1:0];
                result.action = vpfa_pkg::ACT_APPENDED;
                result.data_offset = item.header_length;
                result.data_length = data_len;
                result.frame_length = sum[vpfa_pkg::OUT_LEN_W-1:0];
            end
        end
    end

endmodule

FILE: design/vpfa_out_reg.sv
// vpfa_out_reg: result register of the output channel
// depends on vpfa_pkg
`timescale 1ns / 1ps

module vpfa_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_valid,
    input  vpfa_pkg::result_t load_result,
    input  logic              out_stall,
    output logic              advance,
    output logic              out_valid,
    output vpfa_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    vpfa_pkg::result_t result_reg;

    // register is free when empty or its transfer completes this cycle
    assign advance = !valid_reg || !out_stall;
    assign valid_next = advance ? load_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && load_valid)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign result = result_reg;

endmodule

FILE: design/video_payload_frame_assembler.sv
// Video payload frame assembler top level: handshakes, configuration and frame state
// depends on vpfa_pkg, vpfa_in_reg, vpfa_decide, vpfa_out_reg
`timescale 1ns / 1ps

// One packet descriptor is taken per clock cycle while in_stall is low and gives exactly one
// result: the descriptor lands in an input register, the decision logic evaluates it
// against the frame state (frame id, skip flag, open flag, byte count) and the result
// register captures the outcome while the state updates at the same edge, so the next
// descriptor always sees the effect of the previous one. The per-cycle rate is set by the
// state register loop, whose longest path is one frame-length add and capacity compare.
// in_stall rises only when both registers hold data and the output is stalled. Write the
// configuration registers only while no descriptor is in flight; writing stream_enable
// low also releases any frame buffer held.

module video_payload_frame_assembler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [vpfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vpfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         xfer_status,
    input  logic [vpfa_pkg::COUNT_W-1:0]       byte_count,
    input  logic [vpfa_pkg::HLEN_W-1:0]        header_length,
    input  logic                               frame_id_bit,
    input  logic                               header_error_bit,
    input  logic                               end_frame_bit,
    input  logic                               buffer_free,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [3:0]                         action,
    output logic [vpfa_pkg::HLEN_W-1:0]        data_offset,
    output logic [vpfa_pkg::COUNT_W-1:0]       data_length,
    output logic                               frame_restart,
    output logic [vpfa_pkg::OUT_LEN_W-1:0]     frame_length
);

    vpfa_pkg::item_t   in_item;
    vpfa_pkg::item_t   item;
    logic              item_valid;
    logic              advance;
    vpfa_pkg::cfg_t    cfg_reg;
    vpfa_pkg::cfg_t    cfg_next;
    vpfa_pkg::state_t  state_reg;
    vpfa_pkg::state_t  state_next;
    vpfa_pkg::state_t  decide_state;
    vpfa_pkg::result_t decide_result;
    vpfa_pkg::result_t result;

    assign in_item.xfer_status = xfer_status;
    assign in_item.byte_count = byte_count;
    assign in_item.header_length = header_length;
    assign in_item.frame_id_bit = frame_id_bit;
    assign in_item.header_error_bit = header_error_bit;
    assign in_item.end_frame_bit = end_frame_bit;
    assign in_item.buffer_free = buffer_free;

    vpfa_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .in_stall   (in_stall),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    vpfa_decide u_decide (
        .item       (item),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .result     (decide_result),
        .state_next (decide_state)
    );

    vpfa_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (item_valid),
        .load_result (decide_result),
        .out_stall   (out_stall),
        .advance     (advance),
        .out_valid   (out_valid),
        .result      (result)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        state_next = state_reg;
        if (advance && item_valid)
        begin
            state_next = decide_state;
        end
        if (cfg_write)
        begin
            unique case (cfg_index)
                vpfa_pkg::REG_STREAM_ENABLE:
                begin
                    cfg_next.stream_enable = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        state_next.open = 1'b0;
                        state_next.bytes = '0;
                    end
                end
                vpfa_pkg::REG_MAX_FRAME_BYTES:
                begin
                    cfg_next.max_frame_bytes = cfg_data;
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stream_enable <= 1'b0;
            cfg_reg.max_frame_bytes <= '1;
            state_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            state_reg <= state_next;
        end
    end

    assign action = result.action;
    assign data_offset = result.data_offset;
    assign data_length = result.data_length;
    assign frame_restart = result.frame_restart;
    assign frame_length = result.frame_length;

endmodule

FILE: tb/video_payload_frame_assembler_tb.sv
// video_payload_frame_assembler_tb: self-checking bench for the video payload frame assembler
// directed table, then random frame sequences, checked against table entries or an in-bench frame predictor
// depends on vpfa_pkg and video_payload_frame_assembler
`timescale 1ns / 1ps

module video_payload_frame_assembler_tb;

    localparam logic [2:0] ST_TIMED_OUT = 3'd6;
    localparam logic [2:0] ST_SKIPPED = 3'd7;
    localparam int ITEM_W = $bits(vpfa_pkg::item_t);

    typedef struct packed {
        logic                            is_cfg;
        logic [vpfa_pkg::CFG_IDX_W-1:0]  idx;
        logic [vpfa_pkg::CFG_DATA_W-1:0] data;
        vpfa_pkg::item_t                 pkt;
        logic                            typed;
        vpfa_pkg::result_t               want;
    } row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [vpfa_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [vpfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    vpfa_pkg::item_t                 pkt_drv = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [3:0]                      action;
    logic [vpfa_pkg::HLEN_W-1:0]     data_offset;
    logic [vpfa_pkg::COUNT_W-1:0]    data_length;
    logic                            frame_restart;
    logic [vpfa_pkg::OUT_LEN_W-1:0]  frame_length;

    // predictor copy of registers and frame state
    vpfa_pkg::cfg_t    regs = '{stream_enable: 1'b0, max_frame_bytes: 24'hFFFFFF};
    vpfa_pkg::state_t  frame_st = '0;
    vpfa_pkg::result_t predicted_results[$];

    int   tx_mode = 2;
    int   rx_mode = 2;
    logic gen_fid = 1'b0;
    int   frame_left = 0;
    int   mismatches = 0;
    int   packets_sent = 0;
    int   live_packets = 0;
    int   reg_writes = 0;
    int   frames_closed = 0;
    int   overflows = 0;

    video_payload_frame_assembler dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .xfer_status      (pkt_drv.xfer_status),
        .byte_count       (pkt_drv.byte_count),
        .header_length    (pkt_drv.header_length),
        .frame_id_bit     (pkt_drv.frame_id_bit),
        .header_error_bit (pkt_drv.header_error_bit),
        .end_frame_bit    (pkt_drv.end_frame_bit),
        .buffer_free      (pkt_drv.buffer_free),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .action           (action),
        .data_offset      (data_offset),
        .data_length      (data_length),
        .frame_restart    (frame_restart),
        .frame_length     (frame_length)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    function automatic int draw_wait(input int mode);
        if (mode == 0)
        begin
            return 0;
        end
        if (mode == 1)
        begin
            return $urandom_range(0, 16);
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
    endfunction

    function automatic void apply_register(input logic [vpfa_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [vpfa_pkg::CFG_DATA_W-1:0] value);
        if (idx == vpfa_pkg::REG_STREAM_ENABLE)
        begin
            regs.stream_enable = value[0];
            // disabling the stream drops any held buffer
            if (!value[0])
            begin
                frame_st.open = 1'b0;
                frame_st.bytes = '0;
            end
        end
        else
        begin
            regs.max_frame_bytes = value;
        end
    endfunction

    function automatic vpfa_pkg::result_t assemble_packet(input vpfa_pkg::item_t p);
        vpfa_pkg::result_t            r;
        logic [vpfa_pkg::COUNT_W-1:0] cnt;
        logic [vpfa_pkg::COUNT_W-1:0] len;
        logic [vpfa_pkg::SUM_W-1:0]   sum;
        logic [vpfa_pkg::SUM_W-1:0]   cap;
        r = '0;
        r.frame_length = vpfa_pkg::OUT_LEN_W'(frame_st.bytes);
        cnt = (p.byte_count > vpfa_pkg::MAX_PKT) ? vpfa_pkg::MAX_PKT : p.byte_count;
        cap = vpfa_pkg::SUM_W'(regs.max_frame_bytes);
        if (cap > vpfa_pkg::LEN_MASK)
        begin
            cap = vpfa_pkg::LEN_MASK;
        end
        if (!regs.stream_enable)
        begin
            r.action = vpfa_pkg::ACT_IGNORED;
            return r;
        end
        if (p.xfer_status == vpfa_pkg::ST_NO_DEVICE || p.xfer_status == vpfa_pkg::ST_CANCELED)
        begin
            r.action = vpfa_pkg::ACT_ABANDON;
            return r;
        end
        if (p.xfer_status == vpfa_pkg::ST_ERROR || p.xfer_status == vpfa_pkg::ST_OVERFLOW
            || p.xfer_status == vpfa_pkg::ST_STALL)
        begin
            frame_st.skip = 1'b1;
            r.action = vpfa_pkg::ACT_USB_ERR;
            return r;
        end
        if (p.xfer_status != vpfa_pkg::ST_COMPLETED || p.byte_count == '0)
        begin
            r.action = vpfa_pkg::ACT_NOTHING;
            return r;
        end
        if (p.frame_id_bit != frame_st.cur_fid)
        begin
            frame_st.cur_fid = p.frame_id_bit;
            frame_st.skip = 1'b0;
            if (!frame_st.open)
            begin
                if (!p.buffer_free)
                begin
                    frame_st.skip = 1'b1;
                    r.action = vpfa_pkg::ACT_NO_BUF;
                    r.frame_length = '0;
                    return r;
                end
                frame_st.open = 1'b1;
            end
            else
            begin
                r.frame_restart = 1'b1;
            end
            frame_st.bytes = '0;
            r.frame_length = '0;
        end
        else if (frame_st.skip)
        begin
            r.action = vpfa_pkg::ACT_SKIPPED;
            return r;
        end
        if (cnt <= p.header_length)
        begin
            r.action = vpfa_pkg::ACT_NOTHING;
            return r;
        end
        if (p.header_error_bit)
        begin
            frame_st.skip = 1'b1;
            r.action = vpfa_pkg::ACT_HDR_ERR;
            return r;
        end
        len = cnt - p.header_length;
        sum = frame_st.bytes + len;
        if (!frame_st.open || sum > cap)
        begin
            frame_st.skip = 1'b1;
            r.action = vpfa_pkg::ACT_OVERFLOW;
            return r;
        end
        r.data_offset = p.header_length;
        r.data_length = len;
        r.frame_length = sum[vpfa_pkg::OUT_LEN_W-1:0];
        if (p.end_frame_bit)
        begin
            r.action = vpfa_pkg::ACT_DONE;
            frame_st.open = 1'b0;
            frame_st.bytes = '0;
        end
        else
        begin
            r.action = vpfa_pkg::ACT_APPENDED;
            frame_st.bytes = sum[vpfa_pkg::FRAME_LEN_BITS-1:0];
        end
        return r;
    endfunction

    function automatic row_t pkt_row(input logic [2:0] st,
                                     input logic [vpfa_pkg::COUNT_W-1:0] cnt,
                                     input logic [vpfa_pkg::HLEN_W-1:0] hl, input logic fid,
                                     input logic herr, input logic eof, input logic bfree,
                                     input logic typed, input logic [3:0] act);
        row_t r;
        r = '0;
        r.pkt.xfer_status = st;
        r.pkt.byte_count = cnt;
        r.pkt.header_length = hl;
        r.pkt.frame_id_bit = fid;
        r.pkt.header_error_bit = herr;
        r.pkt.end_frame_bit = eof;
        r.pkt.buffer_free = bfree;
        r.typed = typed;
        r.want.action = act;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [vpfa_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [vpfa_pkg::CFG_DATA_W-1:0] value);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = value;
        return r;
    endfunction

    // mostly whole frames with random content, some broken frames and pure noise
    function automatic vpfa_pkg::item_t next_packet();
        vpfa_pkg::item_t p;
        p = vpfa_pkg::item_t'(ITEM_W'($urandom));
        if ($urandom_range(0, 99) < 80)
        begin
            if (frame_left == 0)
            begin
                gen_fid = ~gen_fid;
                frame_left = $urandom_range(1, 10);
            end
            frame_left--;
            p.xfer_status = vpfa_pkg::ST_COMPLETED;
            p.byte_count = ($urandom_range(0, 3) == 0) ?
                           vpfa_pkg::COUNT_W'($urandom_range(1, vpfa_pkg::MAX_PACKET_BYTES)) :
                           vpfa_pkg::COUNT_W'($urandom_range(1, 600));
            p.header_length = ($urandom_range(0, 7) == 0) ?
                              vpfa_pkg::HLEN_W'($urandom_range(0, 255)) :
                              vpfa_pkg::HLEN_W'($urandom_range(2, 12));
            p.frame_id_bit = gen_fid;
            p.header_error_bit = ($urandom_range(0, 39) == 0);
            p.end_frame_bit = (frame_left == 0) && ($urandom_range(0, 7) != 0);
            p.buffer_free = ($urandom_range(0, 9) != 0);
        end
        return p;
    endfunction

    function automatic logic [vpfa_pkg::CFG_DATA_W-1:0] pick_capacity();
        case ($urandom_range(0, 4))
            0: return 24'hFFFFFF;
            1: return 24'd1;
            2: return vpfa_pkg::CFG_DATA_W'($urandom_range(1, 4000));
            3: return vpfa_pkg::CFG_DATA_W'($urandom_range(4000, 100000));
            default: return vpfa_pkg::CFG_DATA_W'($urandom_range(1, 24'hFFFFFF));
        endcase
    endfunction

    task automatic send(input vpfa_pkg::item_t p, input logic typed,
                        input vpfa_pkg::result_t want);
        int                gap;
        vpfa_pkg::result_t exp_res;
        gap = draw_wait(tx_mode);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pkt_drv <= p;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        exp_res = assemble_packet(p);
        if (exp_res.action != vpfa_pkg::ACT_IGNORED)
        begin
            live_packets++;
        end
        predicted_results.push_back(typed ? want : exp_res);
        packets_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vpfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vpfa_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        apply_register(idx, value);
        reg_writes++;
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stalls, then compare each transfer with the oldest prediction
    initial
    begin : result_check
        vpfa_pkg::result_t got;
        vpfa_pkg::result_t want;
        int                stall;
        int                seq;
        seq = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(rx_mode);
            if (stall > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (!(out_valid && !out_stall));
            got = {action, data_offset, data_length, frame_restart, frame_length};
            if (got.action == vpfa_pkg::ACT_DONE)
            begin
                frames_closed++;
            end
            if (got.action == vpfa_pkg::ACT_OVERFLOW)
            begin
                overflows++;
            end
            if (predicted_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing predicted", seq));
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got.action !== want.action)
                begin
                    report($sformatf("result %0d action %0d, predicted %0d",
                                     seq, got.action, want.action));
                end
                if (got.data_offset !== want.data_offset)
                begin
                    report($sformatf("result %0d data_offset %0d, predicted %0d",
                                     seq, got.data_offset, want.data_offset));
                end
                if (got.data_length !== want.data_length)
                begin
                    report($sformatf("result %0d data_length %0d, predicted %0d",
                                     seq, got.data_length, want.data_length));
                end
                if (got.frame_restart !== want.frame_restart)
                begin
                    report($sformatf("result %0d frame_restart %0d, predicted %0d",
                                     seq, got.frame_restart, want.frame_restart));
                end
                if (got.frame_length !== want.frame_length)
                begin
                    report($sformatf("result %0d frame_length %0d, predicted %0d",
                                     seq, got.frame_length, want.frame_length));
                end
            end
            seq++;
        end
    end

    initial
    begin : stimulus
        row_t                            plan[$];
        logic [vpfa_pkg::CFG_DATA_W-1:0] en_word;
        int                              burst;
        int                              spins;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 100, 12, 1, 0, 0, 1, 1,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(cfg_row(vpfa_pkg::REG_STREAM_ENABLE, 1));
        plan.push_back(cfg_row(vpfa_pkg::REG_MAX_FRAME_BYTES, 24'hFFFFFF));
        plan.push_back(pkt_row(vpfa_pkg::ST_NO_DEVICE, 64, 12, 0, 0, 0, 1, 1,
                               vpfa_pkg::ACT_ABANDON));
        plan.push_back(pkt_row(vpfa_pkg::ST_CANCELED, 64, 12, 0, 0, 0, 1, 1,
                               vpfa_pkg::ACT_ABANDON));
        plan.push_back(pkt_row(vpfa_pkg::ST_ERROR, 64, 12, 0, 0, 0, 1, 1,
                               vpfa_pkg::ACT_USB_ERR));
        plan.push_back(pkt_row(ST_TIMED_OUT, 64, 12, 0, 0, 0, 1, 1, vpfa_pkg::ACT_NOTHING));
        plan.push_back(pkt_row(ST_SKIPPED, 64, 12, 0, 0, 0, 1, 1, vpfa_pkg::ACT_NOTHING));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 0, 0, 0, 0, 0, 1, 1,
                               vpfa_pkg::ACT_NOTHING));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 200, 12, 1, 0, 0, 0, 1,
                               vpfa_pkg::ACT_NO_BUF));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 200, 12, 1, 0, 0, 1, 1,
                               vpfa_pkg::ACT_SKIPPED));
        // oversized count saturates, then a full packet with no header
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 4095, 255, 0, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 3072, 0, 0, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 10, 10, 0, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        // new frame id while a frame is open restarts it
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 50, 2, 1, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 50, 2, 1, 1, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 50, 2, 1, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 20, 4, 0, 0, 1, 0, 0,
                               vpfa_pkg::ACT_IGNORED));
        // data with no frame held
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 20, 4, 0, 0, 0, 1, 1,
                               vpfa_pkg::ACT_OVERFLOW));
        // zero capacity, end of frame on a failed append
        plan.push_back(cfg_row(vpfa_pkg::REG_MAX_FRAME_BYTES, 0));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 10, 0, 1, 0, 1, 1, 1,
                               vpfa_pkg::ACT_OVERFLOW));
        plan.push_back(cfg_row(vpfa_pkg::REG_MAX_FRAME_BYTES, 1));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 2, 1, 0, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 2, 1, 0, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        // disabling releases the open frame
        plan.push_back(cfg_row(vpfa_pkg::REG_STREAM_ENABLE, 0));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 100, 12, 1, 0, 0, 1, 1,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(cfg_row(vpfa_pkg::REG_STREAM_ENABLE, 1));
        plan.push_back(cfg_row(vpfa_pkg::REG_MAX_FRAME_BYTES, 24'hFFFFFF));
        plan.push_back(pkt_row(vpfa_pkg::ST_OVERFLOW, 3072, 255, 1, 1, 1, 1, 1,
                               vpfa_pkg::ACT_USB_ERR));
        plan.push_back(pkt_row(vpfa_pkg::ST_STALL, 3072, 255, 1, 1, 1, 1, 1,
                               vpfa_pkg::ACT_USB_ERR));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 255, 255, 1, 0, 0, 1, 0,
                               vpfa_pkg::ACT_IGNORED));
        plan.push_back(pkt_row(vpfa_pkg::ST_COMPLETED, 3072, 0, 1, 1, 1, 1, 0,
                               vpfa_pkg::ACT_IGNORED));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send(plan[i].pkt, plan[i].typed, plan[i].want);
            end
        end

        while (live_packets < 1800)
        begin
            wait_idle();
            en_word = vpfa_pkg::CFG_DATA_W'($urandom);
            en_word[0] = ($urandom_range(0, 7) != 0);
            write_reg(vpfa_pkg::REG_STREAM_ENABLE, en_word);
            write_reg(vpfa_pkg::REG_MAX_FRAME_BYTES, pick_capacity());
            tx_mode = $urandom_range(0, 2);
            rx_mode = $urandom_range(0, 2);
            burst = en_word[0] ? $urandom_range(60, 180) : 20;
            repeat (burst) send(next_packet(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        spins = 0;
        while (predicted_results.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        if (predicted_results.size() != 0)
        begin
            report($sformatf("%0d predicted results never arrived", predicted_results.size()));
        end
        repeat (8) @(posedge clk);

        $display("summary: %0d packets (%0d while streaming), %0d register writes",
                 packets_sent, live_packets, reg_writes);
        $display("summary: %0d frames closed, %0d overflows, %0d mismatches",
                 frames_closed, overflows, mismatches);
        if (mismatches == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/vpfa_pkg.sv
design/vpfa_in_reg.sv
design/vpfa_decide.sv
design/vpfa_out_reg.sv
design/video_payload_frame_assembler.sv
tb/video_payload_frame_assembler_tb.sv
